[rtl/rac64_pkg.sv]
// Shared constants for the rotating Adler-style 64-bit checksum.
package rac64_pkg;

  // Action codes carried on the input channel
  localparam logic ActAbsorb = 1'b0;
  localparam logic ActFinish = 1'b1;

  // Adler modulus
  localparam logic [15:0] AdlerMod = 16'd65521;

  // Seed values, loaded at reset and after every finish
  localparam logic [15:0] SeedLow  = 16'hdeed;
  localparam logic [15:0] SeedHigh = 16'h4134;
  localparam logic [31:0] SeedRot  = 32'h0000_0c1f;
  localparam logic [31:0] SeedMix  = 32'h0000_4a11;

  // Last rotate phase; the phase counts 0, 1, 2 and wraps
  localparam logic [1:0] PhaseLast = 2'd2;

  // Fold a 32-bit word into 16 bits
  function automatic logic [15:0] fold16(input logic [31:0] w);
    return w[31:16] ^ w[15:0];
  endfunction

  // Digest of the seed state, i.e. of an empty message
  localparam logic [63:0] SeedDigest = {SeedMix[31:16] ^ SeedMix[15:0], SeedLow,
                                        SeedRot[31:16] ^ SeedRot[15:0], SeedHigh};

endpackage

[rtl/rotating_adler_checksum64.sv]
// Top level of the rotating Adler-style 64-bit checksum.
//
//  Channel | Direction | Handshake              | Payload
//  --------+-----------+------------------------+------------------------------
//  in      | sink      | in_valid_i / in_stall_o  | in_action_i, in_data_byte_i
//  out     | source    | out_valid_o / out_stall_i | out_digest_o
//
// One item is taken per cycle unless a finish is held off; an absorb updates
// the state at the edge it is accepted, a finish loads its digest into the
// output register at that edge, so the digest is offered from the next cycle.
// The per-byte loop (two modular adds, a 1..3 bit rotate and a 32-bit add)
// is combinational and closes through the state registers.
// Reset (asynchronous, active low) loads the seed state and empties the
// output register.
// Absorbs are always taken. A finish is held off only while a digest sits
// in the output register and the downstream side stalls it.
module rotating_adler_checksum64 (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        in_action_i,
  input  logic [7:0]  in_data_byte_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [63:0] out_digest_o
);
  import rac64_pkg::*;

  // Checksum state
  logic [15:0] sum_low_q,  sum_low_d;
  logic [15:0] sum_high_q, sum_high_d;
  logic [31:0] rot_word_q, rot_word_d;
  logic [31:0] mix_word_q, mix_word_d;
  logic [1:0]  rot_phase_q, rot_phase_d;

  // Output register
  logic        out_valid_q, out_valid_d;
  logic [63:0] digest_q;

  logic        out_full_held;
  logic        in_xfer;
  logic        absorb_xfer;
  logic        finish_xfer;

  logic [16:0] low_sum;
  logic [16:0] high_sum;
  logic [15:0] low_red;
  logic [15:0] high_red;
  logic [31:0] rot_in;
  logic [31:0] rot_out;

  // Output slot busy: a digest is waiting and downstream refuses it
  assign out_full_held = out_valid_q && out_stall_i;
  assign in_stall_o    = out_full_held && (in_action_i == ActFinish);

  assign in_xfer     = in_valid_i && !in_stall_o;
  assign absorb_xfer = in_xfer && (in_action_i == ActAbsorb);
  assign finish_xfer = in_xfer && (in_action_i == ActFinish);

  // Adler sums: each add stays below twice the modulus, so one
  // conditional subtract reduces it.
  always_comb begin
    low_sum  = {1'b0, sum_low_q} + {9'd0, in_data_byte_i};
    low_red  = (low_sum >= {1'b0, AdlerMod}) ? 16'(low_sum - {1'b0, AdlerMod})
                                               : low_sum[15:0];
    high_sum = {1'b0, sum_high_q} + {1'b0, low_red};
    high_red = (high_sum >= {1'b0, AdlerMod}) ? 16'(high_sum - {1'b0, AdlerMod})
                                                : high_sum[15:0];
  end

  // Byte xor then rotate left by phase+1; phase 3 behaves as phase 2
  always_comb begin
    rot_in = rot_word_q ^ {24'd0, in_data_byte_i};
    unique case (rot_phase_q)
      2'd0:    rot_out = {rot_in[30:0], rot_in[31]};
      2'd1:    rot_out = {rot_in[29:0], rot_in[31:30]};
      default: rot_out = {rot_in[28:0], rot_in[31:29]};
    endcase
  end

  // Next state
  always_comb begin
    sum_low_d   = sum_low_q;
    sum_high_d  = sum_high_q;
    rot_word_d  = rot_word_q;
    mix_word_d  = mix_word_q;
    rot_phase_d = rot_phase_q;
    if (finish_xfer) begin
      // reseed after the digest is captured
      sum_low_d   = SeedLow;
      sum_high_d  = SeedHigh;
      rot_word_d  = SeedRot;
      mix_word_d  = SeedMix;
      rot_phase_d = '0;
    end else if (absorb_xfer) begin
      sum_low_d   = low_red;
      sum_high_d  = high_red;
      rot_word_d  = rot_out;
      mix_word_d  = (mix_word_q ^ rot_out) + {16'd0, high_red};
      rot_phase_d = (rot_phase_q >= PhaseLast) ? 2'd0 : rot_phase_q + 2'd1;
    end
  end

  // Output register: loads on a finish, empties when taken downstream
  always_comb begin
    out_valid_d = out_valid_q;
    if (finish_xfer) begin
      out_valid_d = 1'b1;
    end else if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_low_q   <= SeedLow;
      sum_high_q  <= SeedHigh;
      rot_word_q  <= SeedRot;
      mix_word_q  <= SeedMix;
      rot_phase_q <= '0;
      out_valid_q <= 1'b0;
    end else begin
      sum_low_q   <= sum_low_d;
      sum_high_q  <= sum_high_d;
      rot_word_q  <= rot_word_d;
      mix_word_q  <= mix_word_d;
      rot_phase_q <= rot_phase_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Digest payload, no reset needed
  always_ff @(posedge clk_i) begin
    if (finish_xfer) begin
      digest_q <= {fold16(mix_word_q), sum_low_q, fold16(rot_word_q), sum_high_q};
    end
  end

  assign out_valid_o  = out_valid_q;
  assign out_digest_o = digest_q;

endmodule

[rtl/rac64_checker.sv]
// Port-level assertions for the rotating Adler-style checksum, with bind.
module rac64_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_stall_o,
  input logic        in_action_i,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic [63:0] out_digest_o
);
  import rac64_pkg::*;

  logic in_xfer;
  logic fin_xfer;
  logic abs_xfer;

  assign in_xfer  = in_valid_i && !in_stall_o;
  assign fin_xfer = in_xfer && (in_action_i == ActFinish);
  assign abs_xfer = in_xfer && (in_action_i == ActAbsorb);

  // A taken finish shows a digest in the next cycle
  a_finish_gives_digest: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fin_xfer |=> out_valid_o)
    else $error("finish transfer without digest");

  // Absorbs never create a digest on their own
  a_absorb_silent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (abs_xfer && (!out_valid_o || !out_stall_i)) |=> !out_valid_o)
    else $error("digest appeared after absorb");

  // Two finishes in a row: the second digests the empty message
  a_empty_digest: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fin_xfer && $past(fin_xfer)) |=> (out_digest_o == SeedDigest))
    else $error("empty-message digest is not the seed digest");

  // A stalled digest holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> (out_valid_o && $stable(out_digest_o)))
    else $error("stalled digest changed");

endmodule

bind rotating_adler_checksum64 rac64_checker u_rac64_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .in_valid_i     (in_valid_i),
  .in_stall_o     (in_stall_o),
  .in_action_i    (in_action_i),
  .out_valid_o    (out_valid_o),
  .out_stall_i    (out_stall_i),
  .out_digest_o   (out_digest_o)
);

[dv/testbench.sv]
// Self-checking testbench for the rotating Adler-style 64-bit checksum.
`timescale 1ns / 100ps

module testbench;
  import rac64_pkg::*;

  // Cycles the digest sink holds off in one long stretch
  localparam int unsigned LongHold = 200;
  // Cycles without any transfer before the run is declared hung
  localparam int unsigned HangLimit = 3000;
  // Random items after the directed part
  localparam int unsigned RandomItems = 1830;

  // Predicts the digest of each message and checks the digests that come out.
  class digest_scoreboard;
    logic [15:0] sum_lo;
    logic [15:0] sum_hi;
    logic [31:0] rot_w;
    logic [31:0] mix_w;
    logic [1:0]  phase;
    logic [63:0] expected_q[$];
    int unsigned mismatches;
    int unsigned checked;

    function new();
      mismatches = 0;
      checked    = 0;
      reseed();
    endfunction

    function void reseed();
      sum_lo = 16'hdeed;
      sum_hi = 16'h4134;
      rot_w  = 32'h0000_0c1f;
      mix_w  = 32'h0000_4a11;
      phase  = 2'd0;
    endfunction

    // Called once per accepted input transfer
    function void note_input(logic act, logic [7:0] byte_val);
      int unsigned lo_next;
      int unsigned hi_next;
      logic [1:0]  amt;
      logic [31:0] w;
      if (act == ActFinish) begin
        expected_q.push_back({mix_w[31:16] ^ mix_w[15:0], sum_lo,
                              rot_w[31:16] ^ rot_w[15:0], sum_hi});
        reseed();
      end else begin
        lo_next = sum_lo;
        lo_next = (lo_next + byte_val) % AdlerMod;
        hi_next = sum_hi;
        hi_next = (hi_next + lo_next) % AdlerMod;
        sum_lo  = lo_next[15:0];
        sum_hi  = hi_next[15:0];
        // phase 0,1,2 rotates by 1,2,3; a stray phase 3 behaves like 2
        amt     = (phase >= PhaseLast) ? 2'd3 : phase + 2'd1;
        phase   = (phase >= PhaseLast) ? 2'd0 : phase + 2'd1;
        w       = rot_w ^ {24'd0, byte_val};
        rot_w   = (w << amt) | (w >> (32 - amt));
        mix_w   = (mix_w ^ rot_w) + {16'd0, sum_hi};
      end
    endfunction

    task report_mismatch(string what);
      mismatches++;
      if (mismatches <= 20) $display("[%0t] mismatch: %s", $time, what);
    endtask

    task check_digest(logic [63:0] got);
      logic [63:0] want;
      if (expected_q.size() == 0) begin
        report_mismatch($sformatf("digest %h with no finish outstanding", got));
      end else begin
        want = expected_q.pop_front();
        checked++;
        if (got !== want)
          report_mismatch($sformatf("digest %h, expected %h", got, want));
      end
    endtask

    function int unsigned pending();
      return expected_q.size();
    endfunction
  endclass

  logic        clk_i          = 1'b0;
  logic        rst_ni         = 1'b0;
  logic        in_valid_i     = 1'b0;
  logic        in_action_i    = ActAbsorb;
  logic [7:0]  in_data_byte_i = 8'h00;
  logic        out_stall_i    = 1'b0;
  logic        in_stall_o;
  logic        out_valid_o;
  logic [63:0] out_digest_o;

  digest_scoreboard digests = new();

  bit          long_hold_req = 1'b0;  // set by the sender, taken by the sink
  int unsigned long_holds    = 0;
  int unsigned items_sent    = 0;
  int unsigned bytes_sent    = 0;
  int unsigned finishes_sent = 0;
  int unsigned in_held       = 0;     // cycles with an input transfer held off
  int unsigned idle_cycles   = 0;

  always #10 clk_i = ~clk_i;

  rotating_adler_checksum64 i_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .in_action_i    (in_action_i),
    .in_data_byte_i (in_data_byte_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .out_digest_o   (out_digest_o)
  );

  // Offer one item after a random gap and wait for its transfer. Valid is only
  // lowered when a gap follows, so back-to-back items keep it high throughout.
  task automatic send_item(input logic act, input logic [7:0] byte_val,
                           input bit no_gap);
    int unsigned gap;
    gap = no_gap ? 0 : $urandom_range(0, 18);
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i     <= 1'b1;
    in_action_i    <= act;
    in_data_byte_i <= byte_val;
    do @(posedge clk_i); while (in_stall_o);
    digests.note_input(act, byte_val);
    items_sent++;
    if (act == ActFinish) finishes_sent++;
    else bytes_sent++;
  endtask

  // A message: len bytes then a finish. A byte on the finish is noise the
  // block must ignore.
  task automatic send_message(input int unsigned len, input bit no_gap,
                              input bit all_ones);
    logic [7:0] b;
    for (int unsigned k = 0; k < len; k++) begin
      case ($urandom_range(0, 7))
        0:       b = 8'h00;
        1:       b = 8'hff;
        default: b = 8'($urandom);
      endcase
      send_item(ActAbsorb, all_ones ? 8'hff : b, no_gap);
    end
    send_item(ActFinish, 8'($urandom), no_gap);
  endtask

  // Sender pause: nothing is offered until every digest has come back
  task automatic drain_digests();
    in_valid_i <= 1'b0;
    while (digests.pending() != 0) @(posedge clk_i);
  endtask

  // Digest sink: checks every output transfer and stalls at random. Calm
  // stretches (no stall at all) come and go; a long hold-off is taken when
  // the sender asks for one, so the output register backs up into the input.
  initial begin : digest_sink
    int unsigned stall_left;
    bit          calm;
    stall_left = 0;
    calm       = 1'b0;
    wait (rst_ni === 1'b1);
    forever begin
      @(posedge clk_i);
      if (out_valid_o && !out_stall_i) begin
        digests.check_digest(out_digest_o);
        if ($urandom_range(0, 3) == 0) calm = ~calm;
        stall_left = calm ? 0 : $urandom_range(0, 18);
      end
      if (long_hold_req) begin
        long_hold_req = 1'b0;
        stall_left    = LongHold;
        long_holds++;
      end
      out_stall_i <= (stall_left != 0);
      if (stall_left != 0) stall_left--;
    end
  end

  // Watchdog: any transfer on either side resets the count.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && in_stall_o) in_held++;
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
        if (idle_cycles >= HangLimit) begin
          $display("[%0t] no transfer for %0d cycles, %0d digests outstanding",
                   $time, idle_cycles, digests.pending());
          $display("CHECK FAILED");
          $finish;
        end
      end
    end
  end

  // Main sequence: reset, directed corner cases, then random messages with
  // occasional pressure phases, then drain and report.
  initial begin : stimulus
    int unsigned msg_idx;
    int unsigned sel;
    int unsigned len;
    int unsigned target;
    logic [7:0]  corner_bytes[9];
    corner_bytes = '{8'hff, 8'hff, 8'hff, 8'h80, 8'h01, 8'h55, 8'haa, 8'h7f, 8'hfe};

    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // empty messages: digest of the seed state, byte on the finish ignored
    send_item(ActFinish, 8'h00, 1'b0);
    send_item(ActFinish, 8'hff, 1'b1);
    // a single zero byte
    send_item(ActAbsorb, 8'h00, 1'b0);
    send_item(ActFinish, 8'ha5, 1'b0);
    // extreme and alternating bytes through every rotate phase and the wrap
    foreach (corner_bytes[i]) send_item(ActAbsorb, corner_bytes[i], 1'b0);
    send_item(ActFinish, 8'hff, 1'b0);
    // finish straight after finish with no gap
    send_item(ActAbsorb, 8'hff, 1'b1);
    send_item(ActFinish, 8'h5a, 1'b1);
    send_item(ActFinish, 8'h00, 1'b1);
    drain_digests();

    target  = items_sent + RandomItems;
    msg_idx = 0;
    while (items_sent < target) begin
      if (msg_idx == 25 || msg_idx == 90) begin
        // long hold-off downstream while short messages go in back to back:
        // the output register fills and a finish gets held at the input
        long_hold_req = 1'b1;
        repeat (4) send_message($urandom_range(0, 3), 1'b1, 1'b0);
      end else begin
        sel = $urandom_range(0, 19);
        if (sel < 14)      len = $urandom_range(0, 12);
        else if (sel < 19) len = $urandom_range(13, 60);
        else               len = $urandom_range(61, 300);
        // runs of 0xff drive both sums across the modulus
        send_message(len, $urandom_range(0, 3) == 0, $urandom_range(0, 9) == 0);
      end
      // sender pause until every digest has come back
      if (msg_idx % 30 == 29) drain_digests();
      msg_idx++;
    end

    in_valid_i <= 1'b0;
    drain_digests();
    repeat (4) @(posedge clk_i);
    if (digests.pending() != 0)
      digests.report_mismatch($sformatf("%0d digests never came", digests.pending()));

    $display("Run covered %0d messages: %0d bytes absorbed, %0d digests checked",
             finishes_sent, bytes_sent, digests.checked);
    $display("Input held off for %0d cycles; %0d long downstream hold-offs",
             in_held, long_holds);
    if (digests.mismatches == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

[rotating_adler_checksum64.f]
rtl/rac64_pkg.sv
rtl/rotating_adler_checksum64.sv
rtl/rac64_checker.sv
dv/testbench.sv
